// ===== src/assert_macros.svh =====
// Assertion macros shared by the sphere projection RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk_i, off during reset.
`define SVP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("svp assertion failed");

// Same-cycle implication.
`define SVP_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("svp implication failed");

`endif

// ===== src/svp_pkg.sv =====
// Package for the sphere vertex projection core: widths, register codes
// and the payload types passed between pipeline sections. No dependencies.
package svp_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int RAD_W     = COORD_W - 1;
  localparam int D_W       = COORD_W + 1;
  localparam int SH_W      = $clog2(D_W);
  localparam int UNIT_BITS = 30;
  localparam int UNIT_W    = UNIT_BITS;
  localparam int SQP_W     = 2 * UNIT_W;
  localparam int SQ_W      = 2 * UNIT_W + 3;
  localparam int ROOT_W    = UNIT_W + 1;
  localparam int ISQ_STAGES = SQ_W / 2 + 1;
  localparam int Q_W       = UNIT_W + 1;
  localparam int NUM_W     = UNIT_W + UNIT_BITS + 1;
  localparam int DIV_STAGES = Q_W + 1;
  localparam int PROD_W    = Q_W + RAD_W;
  localparam int G_W       = PROD_W - UNIT_BITS;
  localparam int RES_W     = COORD_W + 3;
  localparam int IDX_W     = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_CTR_X  = 2'd0,
    REG_CTR_Y  = 2'd1,
    REG_CTR_Z  = 2'd2,
    REG_RADIUS = 2'd3
  } reg_idx_e;

  typedef logic [2:0][COORD_W-1:0] vec_t;

  typedef struct packed {
    logic [2:0]             neg;
    logic                   degen;
    logic [2:0][UNIT_W-1:0] a;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic [SQ_W-1:0] s;
  } sq_t;

  typedef struct packed {
    side_t             side;
    logic [ROOT_W-1:0] n;
  } root_t;

  typedef struct packed {
    logic [2:0]          neg;
    logic                degen;
    logic [2:0][Q_W-1:0] u;
  } unit_t;

endpackage

// ===== src/svp_stream_if.sv =====
// Valid/ready stream interfaces for vertex input and projected output.
// Depends on svp_pkg.
interface svp_in_if import svp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [COORD_W-1:0] pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface svp_out_if import svp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic [COORD_W-1:0] out_z;
  logic               degenerate;

  modport source (output valid, out_x, out_y, out_z, degenerate, input ready);
  modport sink   (input valid, out_x, out_y, out_z, degenerate, output ready);
endinterface

// ===== src/svp_norm.sv =====
// Front section: center offset, magnitude, exponent alignment, sum of squares.
// Five register stages. Depends on svp_pkg.
module svp_norm import svp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  vec_t ctr_i,
  input  logic up_valid_i,
  output logic up_ready_o,
  input  vec_t pos_i,
  output logic dn_valid_o,
  input  logic dn_ready_i,
  output sq_t  dn_data_o
);

  localparam int NS = 5;

  function automatic logic [SH_W-1:0] msb_pos(logic [D_W-1:0] v);
    logic [SH_W-1:0] p;
    p = '0;
    for (int b = 0; b < D_W; b++) begin
      if (v[b]) p = SH_W'(b);
    end
    return p;
  endfunction

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  assign en[NS] = dn_ready_i;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end
  assign up_ready_o = en[0];
  assign dn_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= up_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  logic [2:0][D_W-1:0]    a1_q, a2_q;
  logic [2:0]             n1_q, n2_q, n3_q, n4_q;
  logic [SH_W-1:0]        p2_q;
  logic                   dg2_q, dg3_q, dg4_q;
  logic [2:0][UNIT_W-1:0] an3_q, an4_q;
  logic [2:0][SQP_W-1:0]  sq4_q;
  logic [2:0][D_W-1:0]    diff, mag;
  logic [D_W-1:0]         any;
  logic [2:0][D_W+UNIT_BITS-2:0] shf;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {pos_i[i][COORD_W-1], pos_i[i]} - {ctr_i[i][COORD_W-1], ctr_i[i]};
      mag[i]  = diff[i][D_W-1] ? D_W'(-diff[i]) : diff[i];
      shf[i]  = {a2_q[i], (UNIT_BITS-1)'(0)} >> p2_q;
    end
    any = a1_q[0] | a1_q[1] | a1_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        a1_q[i] <= mag[i];
        n1_q[i] <= diff[i][D_W-1];
      end
    end
    if (en[1]) begin
      a2_q  <= a1_q;
      n2_q  <= n1_q;
      p2_q  <= msb_pos(any);
      dg2_q <= (any == '0);
    end
    if (en[2]) begin
      for (int i = 0; i < 3; i++) an3_q[i] <= shf[i][UNIT_W-1:0];
      n3_q  <= n2_q;
      dg3_q <= dg2_q;
    end
    if (en[3]) begin
      for (int i = 0; i < 3; i++) sq4_q[i] <= an3_q[i] * an3_q[i];
      an4_q <= an3_q;
      n4_q  <= n3_q;
      dg4_q <= dg3_q;
    end
    if (en[4]) begin
      dn_data_o.s <= SQ_W'(sq4_q[0]) + SQ_W'(sq4_q[1]) + SQ_W'(sq4_q[2]);
      dn_data_o.side.a     <= an4_q;
      dn_data_o.side.neg   <= n4_q;
      dn_data_o.side.degen <= dg4_q;
    end
  end

endmodule

// ===== src/svp_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on svp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module svp_isqrt import svp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  up_valid_i,
  output logic  up_ready_o,
  input  sq_t   up_data_i,
  output logic  dn_valid_o,
  input  logic  dn_ready_i,
  output root_t dn_data_o
);

  localparam int NS = ISQ_STAGES;

  typedef struct packed {
    side_t           side;
    logic [SQ_W-1:0] s;
    logic [SQ_W-1:0] r;
  } isq_t;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;
  isq_t          st_q [NS];
  isq_t          prv  [NS];
  isq_t          nxt  [NS];

  assign en[NS] = dn_ready_i;
  assign prv[0] = '{side: up_data_i.side, s: up_data_i.s, r: '0};

  for (genvar k = 0; k < NS; k++) begin : g_st
    localparam logic [SQ_W-1:0] BIT_K = SQ_W'(1) << (SQ_W - 1 - 2 * k);
    logic [SQ_W-1:0] trial;

    assign en[k] = !v_q[k] || en[k+1];
    if (k > 0) begin : g_lnk
      assign prv[k] = st_q[k-1];
    end

    always_comb begin
      trial = prv[k].r + BIT_K;
      nxt[k].side = prv[k].side;
      if (prv[k].s >= trial) begin
        nxt[k].s = prv[k].s - trial;
        nxt[k].r = (prv[k].r >> 1) + BIT_K;
      end else begin
        nxt[k].s = prv[k].s;
        nxt[k].r = prv[k].r >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) st_q[k] <= nxt[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= up_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign up_ready_o     = en[0];
  assign dn_valid_o     = v_q[NS-1];
  assign dn_data_o.side = st_q[NS-1].side;
  assign dn_data_o.n    = st_q[NS-1].r[ROOT_W-1:0];

  // aligned magnitudes keep the root at or above 2^29
  `SVP_ASSERT_IMP(a_root_range, dn_valid_o && !dn_data_o.side.degen,
                  dn_data_o.n[ROOT_W-1:ROOT_W-2] != 2'b00)

endmodule

// ===== src/svp_div.sv =====
// Three-lane pipelined restoring divider: unit vector in Q1.30 with rounding.
// One quotient bit per stage after the first. Depends on svp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module svp_div import svp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  up_valid_i,
  output logic  up_ready_o,
  input  root_t up_data_i,
  output logic  dn_valid_o,
  input  logic  dn_ready_i,
  output unit_t dn_data_o
);

  localparam int NS = DIV_STAGES;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [Q_W-1:0]   rem;
    logic [Q_W-1:0]   q;
  } lane_t;

  typedef struct packed {
    logic [2:0]        neg;
    logic              degen;
    logic [ROOT_W-1:0] n;
    lane_t [2:0]       ln;
  } dst_t;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;
  dst_t          st_q [NS];
  dst_t          nxt  [NS];

  assign en[NS] = dn_ready_i;

  // partial remainder starts at the top bits; the quotient stays below 2^31
  always_comb begin
    nxt[0].neg   = up_data_i.side.neg;
    nxt[0].degen = up_data_i.side.degen;
    nxt[0].n     = up_data_i.n;
    for (int i = 0; i < 3; i++) begin
      nxt[0].ln[i].num = NUM_W'({up_data_i.side.a[i], UNIT_BITS'(0)})
                       + NUM_W'(up_data_i.n >> 1);
      nxt[0].ln[i].rem = Q_W'(nxt[0].ln[i].num[NUM_W-1:Q_W]);
      nxt[0].ln[i].q   = '0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_st
    assign en[k] = !v_q[k] || en[k+1];

    if (k == 0) begin : g_prep
      always_ff @(posedge clk_i) begin
        if (en[k]) st_q[k] <= nxt[k];
      end
    end else begin : g_itr
      localparam int J = Q_W - k;
      logic [2:0][Q_W:0] t;

      always_comb begin
        nxt[k] = st_q[k-1];
        for (int i = 0; i < 3; i++) begin
          t[i] = {st_q[k-1].ln[i].rem, st_q[k-1].ln[i].num[J]};
          if (t[i] >= {1'b0, st_q[k-1].n}) begin
            nxt[k].ln[i].rem  = Q_W'(t[i] - {1'b0, st_q[k-1].n});
            nxt[k].ln[i].q[J] = 1'b1;
          end else begin
            nxt[k].ln[i].rem = t[i][Q_W-1:0];
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (en[k]) st_q[k] <= nxt[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= up_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign up_ready_o      = en[0];
  assign dn_valid_o      = v_q[NS-1];
  assign dn_data_o.neg   = st_q[NS-1].neg;
  assign dn_data_o.degen = st_q[NS-1].degen;
  for (genvar i = 0; i < 3; i++) begin : g_out
    assign dn_data_o.u[i] = st_q[NS-1].ln[i].q;
  end

  `SVP_ASSERT_IMP(a_unit_max, dn_valid_o && !dn_data_o.degen,
                  (dn_data_o.u[0] <= ((Q_W'(1) << UNIT_BITS) + Q_W'(1))) &&
                  (dn_data_o.u[1] <= ((Q_W'(1) << UNIT_BITS) + Q_W'(1))) &&
                  (dn_data_o.u[2] <= ((Q_W'(1) << UNIT_BITS) + Q_W'(1))))

endmodule

// ===== src/sphere_vertex_projection_core.sv =====
// Top level of the sphere vertex projection core: config registers, the
// radius scale and center add stages, output register. Uses svp_pkg,
// svp_stream_if, svp_norm, svp_isqrt, svp_div and assert_macros.svh.
//
//   channel  dir  handshake     payload
//   vtx_i    in   valid/ready   pos_x, pos_y, pos_z
//   prj_o    out  valid/ready   out_x, out_y, out_z, degenerate
//   cfg      in   cfg_we_i      cfg_idx_i, cfg_data_i
//
// One vertex per cycle while prj_o is ready; the path runs through the 32-stage square root
// and 32-stage divider between 5 front stages and 2 back stages.
// Every stage holds its transaction while the next one is full, so a stall
// at prj_o fills the bubbles before vtx_i.ready drops.
// Reset clears valid bits, the center to 0 and the radius to 1.0.
`include "assert_macros.svh"
module sphere_vertex_projection_core import svp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  svp_in_if.sink             vtx_i,
  svp_out_if.source          prj_o,
  input  logic               cfg_we_i,
  input  logic [IDX_W-1:0]   cfg_idx_i,
  input  logic [COORD_W-1:0] cfg_data_i
);

  vec_t             ctr_q;
  logic [RAD_W-1:0] rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
      rad_q <= RAD_W'(1) << FRAC_BITS;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_CTR_X:  ctr_q[0] <= cfg_data_i;
        REG_CTR_Y:  ctr_q[1] <= cfg_data_i;
        REG_CTR_Z:  ctr_q[2] <= cfg_data_i;
        REG_RADIUS: rad_q    <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  vec_t  pos;
  logic  nrm_v, nrm_r, isq_v, isq_r, div_v, div_r;
  sq_t   nrm_d;
  root_t isq_d;
  unit_t div_d;

  assign pos = {vtx_i.pos_z, vtx_i.pos_y, vtx_i.pos_x};

  svp_norm u_norm (
    .clk_i, .rst_ni, .ctr_i(ctr_q),
    .up_valid_i(vtx_i.valid), .up_ready_o(vtx_i.ready), .pos_i(pos),
    .dn_valid_o(nrm_v), .dn_ready_i(nrm_r), .dn_data_o(nrm_d)
  );

  svp_isqrt u_isqrt (
    .clk_i, .rst_ni,
    .up_valid_i(nrm_v), .up_ready_o(nrm_r), .up_data_i(nrm_d),
    .dn_valid_o(isq_v), .dn_ready_i(isq_r), .dn_data_o(isq_d)
  );

  svp_div u_div (
    .clk_i, .rst_ni,
    .up_valid_i(isq_v), .up_ready_o(isq_r), .up_data_i(isq_d),
    .dn_valid_o(div_v), .dn_ready_i(div_r), .dn_data_o(div_d)
  );

  // back end: radius product, then round, add center, saturate
  logic [1:0] v_q;
  logic [2:0] en;

  assign en[2] = prj_o.ready;
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];
  assign div_r = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= div_v;
      if (en[1]) v_q[1] <= v_q[0];
    end
  end

  logic [2:0][PROD_W-1:0]  prod_q;
  logic [2:0]              neg_q;
  logic                    dg_q;
  logic [2:0][PROD_W-1:0]  rnd;
  logic [2:0][G_W-1:0]     g;
  logic [2:0][RES_W-1:0]   res;
  vec_t                    sat, out_q;
  logic                    dgo_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = prod_q[i] + (PROD_W'(1) << (UNIT_BITS - 1));
      g[i]   = rnd[i][PROD_W-1:UNIT_BITS];
      res[i] = neg_q[i] ? RES_W'($signed(ctr_q[i])) - RES_W'(g[i])
                        : RES_W'($signed(ctr_q[i])) + RES_W'(g[i]);
      if (dg_q) begin
        sat[i] = ctr_q[i];
      end else if (res[i][RES_W-1:COORD_W-1] == '0 || res[i][RES_W-1:COORD_W-1] == '1) begin
        sat[i] = res[i][COORD_W-1:0];
      end else begin
        sat[i] = {res[i][RES_W-1], {(COORD_W-1){!res[i][RES_W-1]}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) prod_q[i] <= div_d.u[i] * rad_q;
      neg_q <= div_d.neg;
      dg_q  <= div_d.degen;
    end
    if (en[1]) begin
      out_q <= sat;
      dgo_q <= dg_q;
    end
  end

  assign prj_o.valid      = v_q[1];
  assign prj_o.out_x      = out_q[0];
  assign prj_o.out_y      = out_q[1];
  assign prj_o.out_z      = out_q[2];
  assign prj_o.degenerate = dgo_q;

  `SVP_ASSERT_IMP(a_degen_center, prj_o.valid && prj_o.degenerate,
                  prj_o.out_x == ctr_q[0] && prj_o.out_y == ctr_q[1] &&
                  prj_o.out_z == ctr_q[2])
  `SVP_ASSERT_IMP(a_zero_radius, prj_o.valid && rad_q == '0,
                  prj_o.out_x == ctr_q[0] && prj_o.out_y == ctr_q[1] &&
                  prj_o.out_z == ctr_q[2])

endmodule
